// ----- hw/rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, initial hash, round constants and sigma functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0]        word_t;
  typedef logic [15:0][31:0]  block_t;
  typedef logic [7:0][31:0]   hash_t;

  // Control from the sequencer to the round engine
  typedef struct packed {
    logic start;   // load block and hash, then run one compression
    logic reinit;  // return the hash to its initial value
  } core_ctrl_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned LenPos    = 56;
  localparam logic [7:0]  PadByte   = 8'h80;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hw/rtl/sha256_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One round per cycle over a 16-word schedule window; owns the hash state.
// ----------------------------------------------------------------------------
module sha256_core
  import sha256_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  block_t     block_i,
  output logic       done_o,
  output hash_t      hash_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_ROUND,
    C_ADD
  } core_state_e;

  core_state_e state_q;
  logic [5:0]  rnd_q;
  hash_t       hash_q;
  hash_t       var_q;
  block_t      w_q;

  word_t t1, t2, w_new;
  word_t ch, maj;

  always_comb begin
    ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    maj   = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1    = var_q[7] + big_sigma1(var_q[4]) + ch + round_k(rnd_q) + w_q[0];
    t2    = big_sigma0(var_q[0]) + maj;
    w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      hash_q  <= InitHash;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (ctrl_i.reinit) begin
            hash_q <= InitHash;
          end
          if (ctrl_i.start) begin
            state_q <= C_LOAD;
          end
        end
        C_LOAD: begin
          // block has settled by the cycle after start
          w_q     <= block_i;
          var_q   <= hash_q;
          rnd_q   <= '0;
          state_q <= C_ROUND;
        end
        C_ROUND: begin
          var_q[7] <= var_q[6];
          var_q[6] <= var_q[5];
          var_q[5] <= var_q[4];
          var_q[4] <= var_q[3] + t1;
          var_q[3] <= var_q[2];
          var_q[2] <= var_q[1];
          var_q[1] <= var_q[0];
          var_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[15] <= w_new;
          rnd_q   <= rnd_q + 6'd1;
          if (rnd_q == 6'(NumRounds - 1)) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + var_q[i];
          end
          done_o  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign hash_o = hash_q;

endmodule

// ----- hw/rtl/sha256_message_hasher_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial SHA-256 with padding, length field and eight-word digest output.
// ----------------------------------------------------------------------------
// A message arrives one byte per input transaction (has_byte_i qualifies the
// byte; end_of_message_i closes the message, its own byte hashed first). An
// ordinary byte stalls nothing; the next one may follow straight on. The 64th
// byte of a block starts a compression in the shared round engine: a load
// step, the rounds at one round per cycle and a hash update, and the input
// is stalled until the engine is done. An end transaction adds a padding
// step, one or two compressions (two when fewer than nine bytes remain in
// the block for the pad byte and the length field) and then eight output
// transactions, word 0 first, with last_word_o on word 7. No new input is
// taken until all eight words have been taken; the hash then returns to its
// initial value and the byte count restarts at zero. The bit length counts
// modulo 2^64. No clearing pass.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  // digest channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,   // taking bytes
    ST_BLOCK,  // compressing a full data block
    ST_PAD,    // pad byte and zero fill
    ST_PADC,   // compressing padded block with no room for the length
    ST_LEN,    // write length words, start final compression
    ST_LENC,   // compressing final block
    ST_OUT     // handing out the digest
  } state_e;

  state_e      state_q;
  logic [63:0] cnt_q;        // bytes of the current message
  logic        end_q;        // end seen with the block-completing byte
  logic        len_clr_q;    // block must be cleared before length goes in
  logic [2:0]  idx_q;
  block_t      blk_q, blk_d;

  core_ctrl_t  ctrl;
  logic        core_done;
  hash_t       hash;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic        accept;
  logic [7:0]  put_val;
  logic        put_en;
  logic [63:0] bits;

  assign pos    = cnt_q[5:0];
  assign wi     = pos[5:2];
  assign sh     = {~pos[1:0], 3'b000};  // big-endian byte lane
  assign bits   = {cnt_q[60:0], 3'b000};
  assign accept = in_valid_i && !in_stall_o;

  assign in_stall_o = (state_q != ST_IDLE);

  // Byte placement into the block buffer
  always_comb begin
    put_en  = 1'b0;
    put_val = PadByte;
    blk_d   = blk_q;
    if (state_q == ST_IDLE) begin
      put_en  = accept && has_byte_i;
      put_val = data_byte_i;
    end else if (state_q == ST_PAD) begin
      put_en = 1'b1;
      // words past the pad byte are zero
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > wi) begin
          blk_d[i] = '0;
        end
      end
    end
    if (put_en) begin
      if (pos[1:0] == 2'b00) begin
        blk_d[wi] = {24'h0, put_val} << sh;
      end else begin
        blk_d[wi] = blk_q[wi] | ({24'h0, put_val} << sh);
      end
    end
    if (state_q == ST_LEN) begin
      if (len_clr_q) begin
        blk_d = '0;
      end
      blk_d[14] = bits[63:32];
      blk_d[15] = bits[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  always_comb begin
    ctrl.start  = 1'b0;
    ctrl.reinit = 1'b0;
    unique case (state_q)
      ST_IDLE: ctrl.start = accept && has_byte_i && (pos == 6'd63);
      ST_PAD:  ctrl.start = (pos >= 6'(LenPos));
      ST_LEN:  ctrl.start = 1'b1;
      ST_OUT:  ctrl.reinit = !out_stall_i && (idx_q == 3'd7);
      default: ;
    endcase
  end

  sha256_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (blk_q),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      end_q     <= 1'b0;
      len_clr_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            end_q <= end_of_message_i;
            if (has_byte_i) begin
              cnt_q <= cnt_q + 64'd1;
            end
            if (has_byte_i && (pos == 6'd63)) begin
              state_q <= ST_BLOCK;
            end else if (end_of_message_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_BLOCK: begin
          if (core_done) begin
            state_q <= end_q ? ST_PAD : ST_IDLE;
          end
        end
        ST_PAD: begin
          len_clr_q <= (pos >= 6'(LenPos));
          state_q   <= (pos >= 6'(LenPos)) ? ST_PADC : ST_LEN;
        end
        ST_PADC: begin
          if (core_done) begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          state_q <= ST_LENC;
        end
        ST_LENC: begin
          if (core_done) begin
            idx_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

// ----- test/sha256_message_hasher_top_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams byte-serial messages into the hasher under random back-pressure and
// compares each digest word with a behavioural SHA-256 model kept alongside.
// ----------------------------------------------------------------------------
// Structure:
//   - a tracker class mirrors the hasher: it absorbs every accepted input
//     transaction, pads and compresses at each message end, and queues the
//     eight digest words it expects;
//   - plain tasks drive input transactions, with random sender gaps;
//   - an always block drives random receiver stalls, another checks every
//     accepted digest word against the head of the queue.
// The run moves through three idling phases (receiver-heavy, sender-heavy,
// none) and holds the sender back until the queue drains between them.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top_tb;
  import sha256_pkg::*;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenField   = 56;   // first byte of the length field
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam int unsigned SettleCycles = 80; // one compression plus margin

  localparam logic [31:0] InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one expected transaction on the digest channel
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  position;
    logic        closing;
  } digest_item_t;

  // --------------------------------------------------------------------------
  // Running SHA-256 state and the queue of digest words still to arrive
  // --------------------------------------------------------------------------
  class sha_digest_tracker;
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    logic [63:0]  byte_count;
    digest_item_t pending_words [$];
    int unsigned  errors;

    function new();
      chain = InitChain;
      blk = '{default: '0};
      byte_count = '0;
      errors = 0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // big-endian placement; the first byte of a word clears the rest of it
    function void place_byte(int unsigned pos, logic [7:0] value);
      int unsigned wi;
      int unsigned sh;
      wi = pos / 4;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0) blk[wi] = 32'(value) << sh;
      else blk[wi] |= 32'(value) << sh;
    endfunction

    function void mix_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      v = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // absorb one accepted input transaction
    function void note_byte_item(logic [7:0] value, logic with_byte, logic closing);
      int unsigned pos;
      logic [63:0] bits;
      digest_item_t exp_word;
      if (with_byte) begin
        pos = int'(byte_count[5:0]);
        place_byte(pos, value);
        byte_count++;
        if (pos == BlockBytes - 1) mix_block();
      end
      if (!closing) return;
      pos = int'(byte_count[5:0]);
      place_byte(pos, PadMark);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      // no room left for the length field: an extra block
      if (pos >= LenField) begin
        mix_block();
        blk = '{default: '0};
      end
      bits = byte_count << 3;
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      mix_block();
      for (int i = 0; i < 8; i++) begin
        exp_word = '{word: chain[i], position: 3'(i), closing: (i == 7)};
        pending_words = {pending_words, exp_word};
      end
      chain = InitChain;
      byte_count = '0;
    endfunction

    function void check_digest_word(logic [31:0] word, logic [2:0] position, logic closing);
      digest_item_t exp_item;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %b",
                 $time, word, position, closing);
        errors++;
        return;
      end
      exp_item = pending_words.pop_front();
      if (word !== exp_item.word) begin
        $display("%0t: digest_word: expected %h, actual %h", $time, exp_item.word, word);
        errors++;
      end
      if (position !== exp_item.position) begin
        $display("%0t: word_index: expected %0d, actual %0d", $time, exp_item.position,
                 position);
        errors++;
      end
      if (closing !== exp_item.closing) begin
        $display("%0t: last_word: expected %b, actual %b", $time, exp_item.closing, closing);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_message_hasher_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .has_byte_i,
    .end_of_message_i,
    .out_valid_o,
    .out_stall_i,
    .digest_word_o,
    .word_index_o,
    .last_word_o
  );

  sha_digest_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stall, redrawn every cycle, so gaps land on any word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Digest channel monitor: pre-edge values, one check per accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_digest_word(digest_word_o, word_index_o, last_word_o);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  // One input transaction. An optional random gap comes first; valid only
  // drops for a gap or a drain wait, so it is never lowered and raised in one
  // step. The tracker is told in the same step as the acceptance, so a drain
  // wait straight after an end transaction already sees its eight words.
  task automatic send_item(input logic [7:0] value, input logic with_byte,
                           input logic closing);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= value;
    has_byte_i       <= with_byte;
    end_of_message_i <= closing;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte_item(value, with_byte, closing);
  endtask

  // A message of len bytes with random content. The last byte either rides
  // on the end transaction or the end transaction carries none. Now and then
  // an empty transaction (random, ignored data) is slipped in between bytes.
  task automatic send_message(input int unsigned len, input bit end_with_byte);
    int unsigned body;
    bit          last_carries;
    last_carries = (len != 0) && end_with_byte;
    body = last_carries ? len - 1 : len;
    for (int unsigned i = 0; i < body; i++) begin
      if ($urandom_range(99) < 3) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    send_item(8'($urandom), last_carries, 1'b1);
  endtask

  // Hold the sender until every queued digest word has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly very short messages, now and then one spanning a few words
  function automatic int unsigned pick_length();
    case ($urandom_range(3))
      0, 1, 2: return $urandom_range(8);
      default: return $urandom_range(20, 9);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty transaction alone, then the empty message
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // "abc", last byte on the end transaction
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // extreme byte values, end transaction without a byte
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // ignored data in the middle of a message
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // single-byte message carried by the end transaction
    send_item(8'hff, 1'b1, 1'b1);
    wait_drained();

    // Random phases: receiver-heavy gaps, sender-heavy gaps, then none.
    // Phase one sends a 56-byte message (length field spills into a second
    // block), phase two a short random one, phase three a full 64-byte block.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 34; recv_idle_pct = 46; end
        1:       begin send_idle_pct = 46; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase == 0) send_message(LenField, 1'b1);
      if (phase == 1) send_message(pick_length(), 1'($urandom_range(1)));
      if (phase == 2) send_message(BlockBytes, 1'b0);
      // sender held back until the digest channel is empty
      wait_drained();
    end

    // let any stray output show up before the verdict
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_message_hasher_top.sv
test/sha256_message_hasher_top_tb.sv
